FILE: src/wbss_pkg.sv
package wbss_pkg;

    // Fixed field widths
    localparam int DATA_BITS         = 8;
    localparam int ADDR_FIELD_BITS   = 48;
    localparam int COUNT_BITS        = 32;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int PAT_LEN_BITS      = 6;

    // Pattern registers hold 32 bytes; bytes past them are wildcards
    localparam int PATTERN_REG_BYTES = 32;
    localparam int PAT_IDX_BITS      = 5;
    localparam int PATTERN_REG_BITS  = PATTERN_REG_BYTES * DATA_BITS;

    // Parameter defaults
    localparam int MAX_PATTERN_BYTES_DEF = 32;
    localparam int ADDRESS_BITS_DEF      = 48;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd5;

    typedef struct packed {
        logic [DATA_BITS-1:0]       data_byte;
        logic [ADDR_FIELD_BITS-1:0] byte_address;
        logic                       section_start;
        logic                       scan_end;
    } scan_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]      match_count;
        logic [ADDR_FIELD_BITS-1:0] first_match_address;
        logic                       found;
    } result_word_t;

    // Compare stage to accumulator
    typedef struct packed {
        logic step;   // a byte leaves the compare stage
        logic hit;    // its window matched
        logic last;   // it ended the scan
    } hit_info_t;

endpackage

FILE: src/wbss_cell.sv
module wbss_cell #(
    parameter int CELL_INDEX = 0,
    parameter int LEN_BITS   = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift,
    input  logic [wbss_pkg::DATA_BITS-1:0]        byte_in,
    input  logic                                  valid_in,
    input  logic [LEN_BITS-1:0]                   len,
    input  logic [wbss_pkg::PATTERN_REG_BITS-1:0] pattern_bits,
    input  logic [wbss_pkg::PATTERN_REG_BYTES-1:0] care_bits,
    output logic [wbss_pkg::DATA_BITS-1:0]        byte_out,
    output logic                                  valid_out,
    output logic                                  ok
);

    localparam int KW = (LEN_BITS > 6) ? LEN_BITS : 6;

    logic [wbss_pkg::DATA_BITS-1:0] byte_reg;
    logic                           valid_reg;
    logic [KW-1:0]                  len_w;
    logic [KW-1:0]                  k_w;
    logic                           active;
    logic                           wild;
    logic [wbss_pkg::DATA_BITS-1:0] pat_byte;
    logic                           care;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    // Cell j lines up with pattern byte len-1-j
    always_comb
    begin
        len_w    = KW'(len);
        k_w      = len_w - KW'(CELL_INDEX) - KW'(1);
        active   = KW'(CELL_INDEX) < len_w;
        wild     = k_w >= KW'(wbss_pkg::PATTERN_REG_BYTES);
        pat_byte = pattern_bits[k_w[wbss_pkg::PAT_IDX_BITS-1:0] * wbss_pkg::DATA_BITS +:
                                wbss_pkg::DATA_BITS];
        care     = care_bits[k_w[wbss_pkg::PAT_IDX_BITS-1:0]];
        ok       = !active || (valid_reg && (wild || !care || (byte_reg == pat_byte)));
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

FILE: src/wbss_accum.sv
module wbss_accum #(
    parameter int ABITS    = 48,
    parameter int LEN_BITS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wbss_pkg::hit_info_t             info,
    input  logic [ABITS-1:0]                addr,
    input  logic [LEN_BITS-1:0]             len,
    input  logic                            result_ready,
    output logic                            result_valid,
    output wbss_pkg::result_word_t          result_word
);

    logic [wbss_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [ABITS-1:0]                first_reg, first_next;
    logic                            seen_reg, seen_next;
    logic [ABITS-1:0]                start_addr;
    logic                            valid_reg;
    wbss_pkg::result_word_t          word_reg;

    always_comb
    begin
        start_addr = addr - ABITS'(len) + ABITS'(1);
        count_next = count_reg;
        if (info.hit && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
        seen_next  = seen_reg || info.hit;
        first_next = (info.hit && !seen_reg) ? start_addr : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (info.step)
            begin
                if (info.last)
                begin
                    count_reg <= '0;
                    first_reg <= '0;
                    seen_reg  <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    first_reg <= first_next;
                    seen_reg  <= seen_next;
                end
            end
            if (info.step && info.last)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (info.step && info.last)
        begin
            word_reg.match_count         <= count_next;
            word_reg.first_match_address <= seen_next ?
                wbss_pkg::ADDR_FIELD_BITS'(first_next) : '0;
            word_reg.found               <= seen_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

endmodule

FILE: src/wildcard_byte_signature_scan.sv
// Wildcard byte signature scanner.
// Scan channel (byte_valid/byte_ready/byte_word): one scanned byte per word,
// with its address and section-start / scan-end marks. Result channel
// (result_valid/result_ready/result_word): one word per scan, sent for the
// byte marked scan_end, carrying match count, first match address and found.
// Configuration: cfg_write with cfg_index/cfg_data loads pattern words,
// care mask and pattern length; written between scans.
// Throughput: one byte per cycle while byte_ready is high. A row of
// MAX_PATTERN_BYTES window cells shifts the byte in; each cell checks its
// byte against its pattern byte and the AND of all cell checks is the match,
// taken as the byte leaves the compare stage register. With the result
// register free, result_valid is registered as the scan-end byte leaves it.
// Reset: pattern, mask and length clear to zero, the window empties, counts
// clear and no result is pending.
// Stall: a held result stays put; bytes keep flowing until a scan-end byte
// reaches the compare stage while the result register is still full, then
// byte_ready drops until the result is taken.
module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS      = wbss_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  wbss_pkg::scan_word_t                byte_word,
    output logic                                result_valid,
    input  logic                                result_ready,
    output wbss_pkg::result_word_t              result_word,
    input  logic                                cfg_write,
    input  logic [wbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wbss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // Address bits actually carried: the field is 48 bits wide
    localparam int ABITS    = (ADDRESS_BITS < wbss_pkg::ADDR_FIELD_BITS) ?
                              ADDRESS_BITS : wbss_pkg::ADDR_FIELD_BITS;
    localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);

    // Configuration registers
    logic [wbss_pkg::CFG_DATA_BITS-1:0]     pat0_reg, pat1_reg, pat2_reg, pat3_reg;
    logic [wbss_pkg::PATTERN_REG_BYTES-1:0] care_reg;
    logic [wbss_pkg::PAT_LEN_BITS-1:0]      plen_reg;

    // Compare stage: the byte whose window sits in the cells
    logic             a_valid_reg;
    logic             a_end_reg;
    logic [ABITS-1:0] a_addr_reg;

    logic                                   accept;
    logic                                   a_go;
    logic                                   clear;
    logic [LEN_BITS-1:0]                    len_eff;
    logic [wbss_pkg::PATTERN_REG_BITS-1:0]  pattern_bits;
    logic [MAX_PATTERN_BYTES-1:0]           cell_ok;
    logic [MAX_PATTERN_BYTES-1:0]           cell_valid;
    logic [wbss_pkg::DATA_BITS-1:0]         cell_byte [MAX_PATTERN_BYTES];
    wbss_pkg::hit_info_t                    info;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat0_reg <= '0;
            pat1_reg <= '0;
            pat2_reg <= '0;
            pat3_reg <= '0;
            care_reg <= '0;
            plen_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wbss_pkg::CFG_PATTERN_WORD_0: pat0_reg <= cfg_data;
                wbss_pkg::CFG_PATTERN_WORD_1: pat1_reg <= cfg_data;
                wbss_pkg::CFG_PATTERN_WORD_2: pat2_reg <= cfg_data;
                wbss_pkg::CFG_PATTERN_WORD_3: pat3_reg <= cfg_data;
                wbss_pkg::CFG_CARE_MASK:
                    care_reg <= cfg_data[wbss_pkg::PATTERN_REG_BYTES-1:0];
                wbss_pkg::CFG_PATTERN_LENGTH:
                    plen_reg <= cfg_data[wbss_pkg::PAT_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign pattern_bits = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};

    // Lengths past the window act as a full-window pattern
    always_comb
    begin
        if (int'(plen_reg) > MAX_PATTERN_BYTES)
        begin
            len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = LEN_BITS'(plen_reg);
        end
    end

    // A scan-end byte in the compare stage needs a free result slot
    assign a_go       = a_valid_reg && (!a_end_reg || !result_valid || result_ready);
    assign byte_ready = !a_valid_reg || a_go;
    assign accept     = byte_valid && byte_ready;

    // Window empties at a section start and after a scan end
    assign clear = byte_word.section_start || a_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_end_reg   <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
            a_end_reg   <= byte_word.scan_end;
        end
        else if (a_go)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_addr_reg <= byte_word.byte_address[ABITS-1:0];
        end
    end

    // Window cells, cell 0 newest
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        logic [wbss_pkg::DATA_BITS-1:0] b_in;
        logic                           v_in;

        if (j == 0)
        begin : g_head
            assign b_in = byte_word.data_byte;
            assign v_in = 1'b1;
        end
        else
        begin : g_body
            assign b_in = cell_byte[j-1];
            assign v_in = cell_valid[j-1] && !clear;
        end

        wbss_cell #(
            .CELL_INDEX (j),
            .LEN_BITS   (LEN_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .shift        (accept),
            .byte_in      (b_in),
            .valid_in     (v_in),
            .len          (len_eff),
            .pattern_bits (pattern_bits),
            .care_bits    (care_reg),
            .byte_out     (cell_byte[j]),
            .valid_out    (cell_valid[j]),
            .ok           (cell_ok[j])
        );
    end

    always_comb
    begin
        info.step = a_go;
        info.hit  = a_go && (len_eff != '0) && (&cell_ok);
        info.last = a_end_reg;
    end

    wbss_accum #(
        .ABITS    (ABITS),
        .LEN_BITS (LEN_BITS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .info         (info),
        .addr         (a_addr_reg),
        .len          (len_eff),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result_word  (result_word)
    );

endmodule
